[src/assert_macros.svh]
// Assertion helpers shared by the allocator modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/lba_pkg.sv]
// ----------------------------------------------------------------------------
// lba_pkg
// Shared constants, codes and controller/datapath interface types of the
// linked block allocator.
// ----------------------------------------------------------------------------
package lba_pkg;

    localparam int BLOCK_COUNT = 64;
    localparam int AW          = (BLOCK_COUNT > 1) ? $clog2(BLOCK_COUNT) : 1;

    localparam int BLK_W  = 6;
    localparam int PTR_W  = 7;
    localparam int OWN_W  = 8;
    localparam int LEN_W  = 7;
    localparam int BYTE_W = 8;
    localparam int CNT_W  = 7;

    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 32;

    localparam logic [PTR_W-1:0] END_MARK = PTR_W'(64);
    localparam logic [PTR_W-1:0] BC_P     = PTR_W'(BLOCK_COUNT);
    localparam logic [CNT_W-1:0] CNT_MAX  = '1;

    typedef enum logic [1:0] {
        OP_LINK  = 2'd0,
        OP_ALLOC = 2'd1,
        OP_DATA  = 2'd2,
        OP_QUERY = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        RD_CURSOR = 2'd0,
        RD_CUR    = 2'd1,
        RD_FILL   = 2'd2,
        RD_SCAN   = 2'd3
    } t_rd_sel;

    typedef enum logic [1:0] {
        OUT_ACK   = 2'd0,
        OUT_PEND  = 2'd1,
        OUT_FINAL = 2'd2
    } t_out_sel;

    typedef struct packed {
        logic     accept;
        logic     link_wr;
        logic     rd_en;
        t_rd_sel  rd_sel;
        logic     walk_start;
        logic     walk_wr;
        logic     walk_adv;
        logic     alloc_fin;
        logic     fill_wr;
        logic     fill_adv;
        logic     scan_chk;
        logic     scan_inc;
        logic     out_ld;
        t_out_sel out_sel;
    } t_cmd;

    typedef struct packed {
        logic alloc_ok;
        logic walk_go;
        logic fill_ok;
        logic scan_match;
        logic pend_valid;
        logic scan_done;
        logic out_free;
    } t_sts;

endpackage

[src/lba_datapath.sv]
// ----------------------------------------------------------------------------
// lba_datapath
// Block tables, allocator registers, query pending slot and output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lba_datapath (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  lba_pkg::t_cmd                    i_cmd,
    output lba_pkg::t_sts                    o_sts,
    input  lba_pkg::t_op                     i_op,
    input  logic [lba_pkg::BLK_W-1:0]        i_block_id,
    input  logic [lba_pkg::PTR_W-1:0]        i_successor,
    input  logic [lba_pkg::OWN_W-1:0]        i_owner_id,
    input  logic [lba_pkg::LEN_W-1:0]        i_length,
    input  logic [lba_pkg::BYTE_W-1:0]       i_data_byte,
    input  logic                             i_m_tready,
    output logic                             o_m_tvalid,
    output logic [lba_pkg::OUT_TDATA_W-1:0]  o_m_tdata,
    output logic [1:0]                       o_m_tuser,
    output logic                             o_m_tlast
);

    // tables
    logic [lba_pkg::PTR_W-1:0]    link_mem  [lba_pkg::BLOCK_COUNT];
    logic [lba_pkg::OWN_W-1:0]    owner_mem [lba_pkg::BLOCK_COUNT];
    logic [lba_pkg::BYTE_W-1:0]   byte_mem  [lba_pkg::BLOCK_COUNT];
    logic [lba_pkg::BLOCK_COUNT-1:0] r_link_vld, r_own_vld, r_byte_vld;

    // registered read data
    logic [lba_pkg::PTR_W-1:0]  r_link_q;
    logic                       r_link_vq;
    logic [lba_pkg::OWN_W-1:0]  r_own_q;
    logic                       r_own_vq;
    logic [lba_pkg::BYTE_W-1:0] r_byte_q;
    logic                       r_byte_vq;

    // current item
    lba_pkg::t_op               r_op;
    logic [lba_pkg::BLK_W-1:0]  r_bid;
    logic [lba_pkg::PTR_W-1:0]  r_succ;
    logic [lba_pkg::OWN_W-1:0]  r_own;
    logic [lba_pkg::LEN_W-1:0]  r_len;
    logic [lba_pkg::BYTE_W-1:0] r_data;

    // allocator state
    logic [lba_pkg::PTR_W-1:0]  r_cursor;
    logic [lba_pkg::CNT_W-1:0]  r_free;
    logic [lba_pkg::PTR_W-1:0]  r_fp;
    logic [lba_pkg::CNT_W-1:0]  r_rem;

    // walk and result scratch
    logic [lba_pkg::PTR_W-1:0]  r_cur;
    logic [lba_pkg::CNT_W-1:0]  r_given;
    logic [lba_pkg::BLK_W-1:0]  r_endb;
    logic [lba_pkg::PTR_W-1:0]  r_start;
    logic                       r_grant;

    // query scan
    logic [lba_pkg::AW-1:0]     r_scan;
    logic                       r_pend_v;
    logic [lba_pkg::BLK_W-1:0]  r_pend_blk;
    logic [lba_pkg::BYTE_W-1:0] r_pend_byte;

    // output register
    logic                            r_o_valid;
    logic [1:0]                      r_o_kind;
    logic                            r_o_last;
    logic [lba_pkg::OUT_TDATA_W-1:0] r_o_data;

    logic [lba_pkg::AW-1:0]          rd_addr;
    logic                            bid_ok;
    logic [lba_pkg::PTR_W-1:0]       succ_fix;
    logic [lba_pkg::PTR_W-1:0]       link_next;
    logic [1:0]                      n_o_kind;
    logic                            n_o_last;
    logic                            n_granted;
    logic [lba_pkg::PTR_W-1:0]       n_start;
    logic [lba_pkg::BLK_W-1:0]       n_endb;
    logic                            n_found;
    logic [lba_pkg::BLK_W-1:0]       n_held;
    logic [lba_pkg::BYTE_W-1:0]      n_hbyte;

    always_comb begin
        case (i_cmd.rd_sel)
            lba_pkg::RD_CURSOR: rd_addr = r_cursor[lba_pkg::AW-1:0];
            lba_pkg::RD_CUR:    rd_addr = r_cur[lba_pkg::AW-1:0];
            lba_pkg::RD_FILL:   rd_addr = r_fp[lba_pkg::AW-1:0];
            lba_pkg::RD_SCAN:   rd_addr = r_scan;
            default:            rd_addr = r_scan;
        endcase
    end

    assign bid_ok    = {1'b0, r_bid} < lba_pkg::BC_P;
    assign succ_fix  = (r_succ < lba_pkg::BC_P) ? r_succ : lba_pkg::END_MARK;
    // never-written link reads as end of chain
    assign link_next = (r_link_vq && (r_link_q < lba_pkg::BC_P)) ? r_link_q
                                                                 : lba_pkg::END_MARK;

    always_comb begin
        o_sts.alloc_ok   = (r_len != '0) && (r_free >= r_len) &&
                           (r_cursor < lba_pkg::BC_P) && !r_own_vq;
        o_sts.walk_go    = (r_given < r_len) && (r_given < lba_pkg::BC_P) &&
                           (r_cur < lba_pkg::BC_P);
        o_sts.fill_ok    = (r_rem != '0) && (r_fp < lba_pkg::BC_P);
        o_sts.scan_match = r_own_vq && (r_own_q == r_own);
        o_sts.pend_valid = r_pend_v;
        o_sts.scan_done  = r_scan == lba_pkg::AW'(lba_pkg::BLOCK_COUNT - 1);
        o_sts.out_free   = !r_o_valid || i_m_tready;
    end

    // memory writes and registered reads
    always_ff @(posedge i_clk) begin
        if (i_cmd.link_wr && bid_ok) begin
            link_mem[r_bid[lba_pkg::AW-1:0]] <= succ_fix;
        end
        if (i_cmd.walk_wr) begin
            owner_mem[r_cur[lba_pkg::AW-1:0]] <= r_own;
        end
        if (i_cmd.fill_wr) begin
            byte_mem[r_fp[lba_pkg::AW-1:0]] <= r_data;
        end
        if (i_cmd.rd_en) begin
            r_link_q  <= link_mem[rd_addr];
            r_own_q   <= owner_mem[rd_addr];
            r_byte_q  <= byte_mem[rd_addr];
            r_link_vq <= r_link_vld[rd_addr];
            r_own_vq  <= r_own_vld[rd_addr];
            r_byte_vq <= r_byte_vld[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link_vld <= '0;
            r_own_vld  <= '0;
            r_byte_vld <= '0;
        end else begin
            if (i_cmd.link_wr && bid_ok) begin
                r_link_vld[r_bid[lba_pkg::AW-1:0]] <= 1'b1;
            end
            if (i_cmd.walk_wr) begin
                r_own_vld[r_cur[lba_pkg::AW-1:0]] <= 1'b1;
            end
            if (i_cmd.fill_wr) begin
                r_byte_vld[r_fp[lba_pkg::AW-1:0]] <= 1'b1;
            end
        end
    end

    // item capture and scratch
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op    <= i_op;
            r_bid   <= i_block_id;
            r_succ  <= i_successor;
            r_own   <= i_owner_id;
            r_len   <= i_length;
            r_data  <= i_data_byte;
            r_given <= '0;
            r_endb  <= '0;
            r_start <= (r_cursor < lba_pkg::BC_P) ? r_cursor : lba_pkg::END_MARK;
            r_scan  <= '0;
        end
        if (i_cmd.walk_start) begin
            r_cur <= r_cursor;
        end
        if (i_cmd.walk_adv) begin
            r_endb  <= r_cur[lba_pkg::BLK_W-1:0];
            r_cur   <= link_next;
            r_given <= r_given + 1'b1;
        end
        if (i_cmd.scan_chk && o_sts.scan_match) begin
            r_pend_blk  <= lba_pkg::BLK_W'(r_scan);
            r_pend_byte <= r_byte_vq ? r_byte_q : '0;
        end
        if (i_cmd.scan_inc) begin
            r_scan <= r_scan + 1'b1;
        end
    end

    // allocator control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor <= '0;
            r_free   <= '0;
            r_fp     <= lba_pkg::END_MARK;
            r_rem    <= '0;
            r_grant  <= 1'b0;
            r_pend_v <= 1'b0;
        end else begin
            if (i_cmd.accept) begin
                r_grant  <= 1'b0;
                r_pend_v <= 1'b0;
            end
            if (i_cmd.link_wr && bid_ok && (r_free != lba_pkg::CNT_MAX)) begin
                r_free <= r_free + 1'b1;
            end
            if (i_cmd.walk_adv && (r_free != '0)) begin
                r_free <= r_free - 1'b1;
            end
            if (i_cmd.alloc_fin) begin
                if (r_given != '0) begin
                    r_cursor <= (r_cur < lba_pkg::BC_P) ? r_cur : lba_pkg::END_MARK;
                    r_fp     <= r_start;
                    r_rem    <= r_given;
                    r_grant  <= 1'b1;
                end else begin
                    r_fp  <= lba_pkg::END_MARK;
                    r_rem <= '0;
                end
            end
            if (i_cmd.fill_adv) begin
                r_fp    <= link_next;
                r_rem   <= r_rem - 1'b1;
                r_grant <= 1'b1;
            end
            if (i_cmd.scan_chk && o_sts.scan_match) begin
                r_pend_v <= 1'b1;
            end
        end
    end

    // result composition
    always_comb begin
        n_o_kind  = r_op;
        n_o_last  = 1'b1;
        n_granted = 1'b0;
        n_start   = '0;
        n_endb    = '0;
        n_found   = 1'b0;
        n_held    = '0;
        n_hbyte   = '0;
        case (i_cmd.out_sel)
            lba_pkg::OUT_ACK: begin
                n_granted = r_grant;
                if (r_op == lba_pkg::OP_ALLOC) begin
                    n_start = r_start;
                    n_endb  = r_endb;
                end
            end
            lba_pkg::OUT_PEND: begin
                n_o_kind = lba_pkg::OP_QUERY;
                n_o_last = 1'b0;
                n_found  = 1'b1;
                n_held   = r_pend_blk;
                n_hbyte  = r_pend_byte;
            end
            lba_pkg::OUT_FINAL: begin
                n_o_kind = lba_pkg::OP_QUERY;
                n_found  = r_pend_v;
                n_held   = r_pend_v ? r_pend_blk : '0;
                n_hbyte  = r_pend_v ? r_pend_byte : '0;
            end
            default: begin
                n_o_kind = r_op;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.out_ld) begin
            r_o_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_ld) begin
            r_o_kind <= n_o_kind;
            r_o_last <= n_o_last;
            r_o_data <= {3'b000, n_hbyte, n_held, n_found, n_endb, n_start, n_granted};
        end
    end

    assign o_m_tvalid = r_o_valid;
    assign o_m_tdata  = r_o_data;
    assign o_m_tuser  = r_o_kind;
    assign o_m_tlast  = r_o_last;

    `ASSERT_IMPLIES(a_walk_in_range, i_clk, i_rst_n, i_cmd.walk_wr, r_cur < lba_pkg::BC_P, "walk writes past last block")
    `ASSERT_IMPLIES(a_out_taken, i_clk, i_rst_n, $fell(r_o_valid) && $past(i_rst_n), $past(i_m_tready), "result dropped before taken")

endmodule

[src/lba_ctrl.sv]
// ----------------------------------------------------------------------------
// lba_ctrl
// Sequencer for link, allocate, data and query transactions.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lba_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    input  lba_pkg::t_op  i_op,
    output logic          o_s_tready,
    input  lba_pkg::t_sts i_sts,
    output lba_pkg::t_cmd o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_LINK,
        S_A_RD,
        S_A_CHK,
        S_W_RD,
        S_W_NX,
        S_A_FIN,
        S_D_RD,
        S_D_NX,
        S_Q_RD,
        S_Q_CHK,
        S_Q_FIN,
        S_EMIT
    } t_state;

    t_state r_state, n_state;
    logic   q_hit_pend;

    assign q_hit_pend = i_sts.scan_match && i_sts.pend_valid;
    assign o_s_tready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.accept = 1'b1;
                    case (i_op)
                        lba_pkg::OP_LINK:  n_state = S_LINK;
                        lba_pkg::OP_ALLOC: n_state = S_A_RD;
                        lba_pkg::OP_DATA:  n_state = S_D_RD;
                        lba_pkg::OP_QUERY: n_state = S_Q_RD;
                        default:           n_state = S_IDLE;
                    endcase
                end
            end
            S_LINK: begin
                o_cmd.link_wr = 1'b1;
                n_state = S_EMIT;
            end
            S_A_RD: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = lba_pkg::RD_CURSOR;
                n_state = S_A_CHK;
            end
            S_A_CHK: begin
                if (i_sts.alloc_ok) begin
                    o_cmd.walk_start = 1'b1;
                    n_state = S_W_RD;
                end else begin
                    n_state = S_A_FIN;
                end
            end
            S_W_RD: begin
                // claim the block and fetch its successor together
                if (i_sts.walk_go) begin
                    o_cmd.walk_wr = 1'b1;
                    o_cmd.rd_en   = 1'b1;
                    o_cmd.rd_sel  = lba_pkg::RD_CUR;
                    n_state = S_W_NX;
                end else begin
                    n_state = S_A_FIN;
                end
            end
            S_W_NX: begin
                o_cmd.walk_adv = 1'b1;
                n_state = S_W_RD;
            end
            S_A_FIN: begin
                o_cmd.alloc_fin = 1'b1;
                n_state = S_EMIT;
            end
            S_D_RD: begin
                if (i_sts.fill_ok) begin
                    o_cmd.fill_wr = 1'b1;
                    o_cmd.rd_en   = 1'b1;
                    o_cmd.rd_sel  = lba_pkg::RD_FILL;
                    n_state = S_D_NX;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_D_NX: begin
                o_cmd.fill_adv = 1'b1;
                n_state = S_EMIT;
            end
            S_Q_RD: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = lba_pkg::RD_SCAN;
                n_state = S_Q_CHK;
            end
            S_Q_CHK: begin
                // a new hit pushes the held one out; wait for the output slot
                if (!q_hit_pend || i_sts.out_free) begin
                    o_cmd.scan_chk = 1'b1;
                    if (q_hit_pend) begin
                        o_cmd.out_ld  = 1'b1;
                        o_cmd.out_sel = lba_pkg::OUT_PEND;
                    end
                    if (i_sts.scan_done) begin
                        n_state = S_Q_FIN;
                    end else begin
                        o_cmd.scan_inc = 1'b1;
                        n_state = S_Q_RD;
                    end
                end
            end
            S_Q_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.out_ld  = 1'b1;
                    o_cmd.out_sel = lba_pkg::OUT_FINAL;
                    n_state = S_IDLE;
                end
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_ld  = 1'b1;
                    o_cmd.out_sel = lba_pkg::OUT_ACK;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    `ASSERT_IMPLIES(a_load_when_free, i_clk, i_rst_n, o_cmd.out_ld, i_sts.out_free, "result loaded over a waiting one")
    `ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, o_cmd.accept, !o_s_tready, "second transaction taken while busy")

endmodule

[src/linked_block_allocator.sv]
// A query sends earlier hits out during the scan and the last with its final result.
// One transaction at a time; the next is taken while the last result waits in
// the output register. Walk and scan: one registered table read and one check per block.
// Reset (i_rst_n low, synchronous) clears table valid bits, cursor and counts.
// ----------------------------------------------------------------------------
// linked_block_allocator
// Linked-list block allocator: chain links, grants, fills and owner queries.
// ----------------------------------------------------------------------------
module linked_block_allocator (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // block_id[5:0], successor[12:6], owner_id[20:13], length[27:21],
    // data_byte[35:28], zero pad[39:36]
    input  logic [lba_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // op[1:0]
    input  logic [1:0]                       s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // granted[0], start_block[7:1], end_block[13:8], found[14],
    // held_block[20:15], held_byte[28:21], zero pad[31:29]
    output logic [lba_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    // kind[1:0]
    output logic [1:0]                       m_axis_tuser,
    output logic                             m_axis_tlast
);

    lba_pkg::t_cmd cmd;
    lba_pkg::t_sts sts;
    lba_pkg::t_op  in_op;

    assign in_op = lba_pkg::t_op'(s_axis_tuser);

    lba_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .i_op       (in_op),
        .o_s_tready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    lba_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_op        (in_op),
        .i_block_id  (s_axis_tdata[5:0]),
        .i_successor (s_axis_tdata[12:6]),
        .i_owner_id  (s_axis_tdata[20:13]),
        .i_length    (s_axis_tdata[27:21]),
        .i_data_byte (s_axis_tdata[35:28]),
        .i_m_tready  (m_axis_tready),
        .o_m_tvalid  (m_axis_tvalid),
        .o_m_tdata   (m_axis_tdata),
        .o_m_tuser   (m_axis_tuser),
        .o_m_tlast   (m_axis_tlast)
    );

endmodule

[verif/linked_block_allocator_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linked_block_allocator_tb
// Self-checking bench for the linked block allocator. Directed transactions
// cover empty tables, refusals, takeover and refill. Random chains are then
// built, granted, filled and queried, with noise mixed in. A final walk over
// every block saturates the free count and drives the cursor off the chain.
// Every result is checked against an in-bench copy of the block tables.
// ----------------------------------------------------------------------------
module linked_block_allocator_tb;

    localparam logic [8:0] UNOWNED     = 9'd256;
    localparam int         CYCLE_LIMIT = 3_000_000;

    typedef struct {
        logic [1:0]                 kind;
        logic                       granted;
        logic [lba_pkg::PTR_W-1:0]  start_block;
        logic [lba_pkg::BLK_W-1:0]  end_block;
        logic                       found;
        logic [lba_pkg::BLK_W-1:0]  held_block;
        logic [lba_pkg::BYTE_W-1:0] held_byte;
        logic                       last;
    } t_alloc_reply;

    logic                            i_clk;
    logic                            i_rst_n       = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [lba_pkg::IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic [1:0]                      s_axis_tuser  = '0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [lba_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
    logic [1:0]                      m_axis_tuser;
    logic                            m_axis_tlast;

    // shadow of the block tables
    logic [lba_pkg::PTR_W-1:0]  link_tab  [lba_pkg::BLOCK_COUNT];
    logic [8:0]                 owner_tab [lba_pkg::BLOCK_COUNT];
    logic [lba_pkg::BYTE_W-1:0] byte_tab  [lba_pkg::BLOCK_COUNT];
    logic [lba_pkg::CNT_W-1:0]  free_cnt;
    logic [lba_pkg::PTR_W-1:0]  cursor;
    logic [lba_pkg::PTR_W-1:0]  fill_ptr;
    logic [lba_pkg::CNT_W-1:0]  fill_left;

    t_alloc_reply awaited_replies[$];
    int           failures       = 0;
    int           items_accepted = 0;
    int           send_idle_pct  = 22;
    int           recv_idle_pct  = 79;
    int unsigned  cycle_count    = 0;

    linked_block_allocator u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("** linked_block_allocator: FAILED **");
            $finish;
        end
    end

    // Updates the shadow tables for one accepted transaction and queues the
    // replies it must produce.
    task automatic block_table_step(lba_pkg::t_op op, logic [lba_pkg::BLK_W-1:0] blk,
                                    logic [lba_pkg::PTR_W-1:0] succ,
                                    logic [lba_pkg::OWN_W-1:0] own,
                                    logic [lba_pkg::LEN_W-1:0] len,
                                    logic [lba_pkg::BYTE_W-1:0] byt);
        t_alloc_reply              r;
        logic [lba_pkg::PTR_W-1:0] walk;
        int                        given;
        int                        hits;
        r = '{default: '0};
        r.kind = op;
        r.last = 1'b1;
        case (op)
            lba_pkg::OP_LINK: begin
                link_tab[blk] = (succ < lba_pkg::BLOCK_COUNT) ? succ : lba_pkg::END_MARK;
                if (free_cnt < lba_pkg::CNT_MAX) free_cnt++;
                awaited_replies.push_back(r);
            end
            lba_pkg::OP_ALLOC: begin
                given = 0;
                r.start_block = cursor;
                if (len != 0 && free_cnt >= len && cursor < lba_pkg::BLOCK_COUNT &&
                    owner_tab[cursor] == UNOWNED) begin
                    walk = cursor;
                    // stops at the requested length, end of chain or after one pass over the table
                    while (given < len && given < lba_pkg::BLOCK_COUNT &&
                           walk < lba_pkg::BLOCK_COUNT) begin
                        owner_tab[walk] = {1'b0, own};
                        r.end_block = walk[lba_pkg::BLK_W-1:0];
                        walk = link_tab[walk];
                        if (free_cnt != 0) free_cnt--;
                        given++;
                    end
                    cursor = walk;
                end
                if (given > 0) begin
                    fill_ptr  = r.start_block;
                    fill_left = lba_pkg::CNT_W'(given);
                    r.granted = 1'b1;
                end else begin
                    fill_ptr    = lba_pkg::END_MARK;
                    fill_left   = '0;
                    r.end_block = '0;
                end
                awaited_replies.push_back(r);
            end
            lba_pkg::OP_DATA: begin
                if (fill_left != 0 && fill_ptr < lba_pkg::BLOCK_COUNT) begin
                    byte_tab[fill_ptr] = byt;
                    fill_ptr = link_tab[fill_ptr];
                    fill_left--;
                    r.granted = 1'b1;
                end
                awaited_replies.push_back(r);
            end
            default: begin
                hits = 0;
                for (int i = 0; i < lba_pkg::BLOCK_COUNT; i++) begin
                    if (owner_tab[i] == {1'b0, own}) begin
                        r.found      = 1'b1;
                        r.last       = 1'b0;
                        r.held_block = lba_pkg::BLK_W'(i);
                        r.held_byte  = byte_tab[i];
                        awaited_replies.push_back(r);
                        hits++;
                    end
                end
                if (hits == 0)
                    awaited_replies.push_back(r);
                else
                    awaited_replies[awaited_replies.size()-1].last = 1'b1;
            end
        endcase
    endtask

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            failures++;
        end
    endtask

    // result side: check each transaction, then pick next cycle's ready
    always @(posedge i_clk) begin
        t_alloc_reply want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (awaited_replies.size() == 0) begin
                $error("result with nothing awaited: tuser %0d tdata %h",
                       m_axis_tuser, m_axis_tdata);
                failures++;
            end else begin
                want = awaited_replies.pop_front();
                check_field("kind",        want.kind,        m_axis_tuser);
                check_field("granted",     want.granted,     m_axis_tdata[0]);
                check_field("start_block", want.start_block, m_axis_tdata[7:1]);
                check_field("end_block",   want.end_block,   m_axis_tdata[13:8]);
                check_field("found",       want.found,       m_axis_tdata[14]);
                check_field("held_block",  want.held_block,  m_axis_tdata[20:15]);
                check_field("held_byte",   want.held_byte,   m_axis_tdata[28:21]);
                check_field("last",        want.last,        m_axis_tlast);
            end
        end
        m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Fields unused by the op get random values; the block must ignore them.
    task automatic send_item(lba_pkg::t_op op, int blk, int succ, int own, int len, int byt);
        logic [lba_pkg::BLK_W-1:0]  b;
        logic [lba_pkg::PTR_W-1:0]  s;
        logic [lba_pkg::OWN_W-1:0]  o;
        logic [lba_pkg::LEN_W-1:0]  l;
        logic [lba_pkg::BYTE_W-1:0] y;
        b = (op == lba_pkg::OP_LINK) ? lba_pkg::BLK_W'(blk) : lba_pkg::BLK_W'($urandom);
        s = (op == lba_pkg::OP_LINK) ? lba_pkg::PTR_W'(succ) : lba_pkg::PTR_W'($urandom);
        o = (op == lba_pkg::OP_ALLOC || op == lba_pkg::OP_QUERY) ? lba_pkg::OWN_W'(own)
                                                                 : lba_pkg::OWN_W'($urandom);
        l = (op == lba_pkg::OP_ALLOC) ? lba_pkg::LEN_W'(len) : lba_pkg::LEN_W'($urandom);
        y = (op == lba_pkg::OP_DATA) ? lba_pkg::BYTE_W'(byt) : lba_pkg::BYTE_W'($urandom);
        if (items_accepted < 120) begin
            send_idle_pct = 22;
            recv_idle_pct = 79;
        end else if (items_accepted < 240) begin
            send_idle_pct = 79;
            recv_idle_pct = 22;
        end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {4'b0, y, l, o, s, b};
        do @(posedge i_clk); while (!s_axis_tready);
        items_accepted++;
        block_table_step(op, b, s, o, l, y);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (awaited_replies.size() != 0) @(posedge i_clk);
    endtask

    task automatic gather_blocks(output int q[$], input bit free_only);
        q = {};
        for (int i = 0; i < lba_pkg::BLOCK_COUNT; i++)
            if (i != cursor && (!free_only || owner_tab[i] == UNOWNED))
                q.push_back(i);
    endtask

    function automatic int take_random(ref int q[$]);
        int idx;
        int v;
        idx = $urandom_range(0, q.size() - 1);
        v   = q[idx];
        q.delete(idx);
        return v;
    endfunction

    // Empty tables: nothing held, nothing to fill, zero length, short free count.
    task automatic test_empty_tables();
        send_item(lba_pkg::OP_QUERY, 0, 0, 0, 0, 0);
        send_item(lba_pkg::OP_DATA, 0, 0, 0, 0, 8'hFF);
        send_item(lba_pkg::OP_ALLOC, 0, 0, 0, 0, 0);
        send_item(lba_pkg::OP_ALLOC, 0, 0, 255, 1, 0);
    endtask

    // Out-of-range successor stored as end of chain; one-block grant and fill.
    task automatic test_first_grant();
        send_item(lba_pkg::OP_LINK, 0, 63, 0, 0, 0);
        send_item(lba_pkg::OP_LINK, 63, 127, 0, 0, 0);
        send_item(lba_pkg::OP_ALLOC, 0, 0, 255, 1, 0);
        send_item(lba_pkg::OP_DATA, 0, 0, 0, 0, 8'hFF);
        send_item(lba_pkg::OP_DATA, 0, 0, 0, 0, 8'h00);
        send_item(lba_pkg::OP_QUERY, 0, 0, 255, 0, 0);
    endtask

    // Walk takes over an owned block; a refused request drops the pending fill.
    task automatic test_takeover_and_refill();
        send_item(lba_pkg::OP_LINK, 63, 0, 0, 0, 0);
        send_item(lba_pkg::OP_LINK, 0, 2, 0, 0, 0);
        send_item(lba_pkg::OP_ALLOC, 0, 0, 0, 2, 0);
        send_item(lba_pkg::OP_DATA, 0, 0, 0, 0, 8'h5A);
        send_item(lba_pkg::OP_ALLOC, 0, 0, 0, 64, 0);
        send_item(lba_pkg::OP_DATA, 0, 0, 0, 0, 8'hA5);
        wait_drained();
        send_item(lba_pkg::OP_QUERY, 0, 0, 0, 0, 0);
        send_item(lba_pkg::OP_QUERY, 0, 0, 255, 0, 0);
    endtask

    // Random chains from the cursor through unowned blocks, always leaving the
    // cursor on a free block so later requests can still be granted.
    task automatic test_random_chains();
        int spare[$];
        int chain[$];
        int n;
        int len;
        int target;
        int own;
        while (items_accepted < 200) begin
            gather_blocks(spare, 1'b1);
            if (spare.size() == 0) break;
            if ($urandom_range(0, 9) < 4) begin
                repeat ($urandom_range(1, 3)) begin
                    case ($urandom_range(0, 4))
                        0: send_item(lba_pkg::OP_LINK, $urandom_range(0, 63),
                                     $urandom_range(0, 127), 0, 0, 0);
                        1: send_item(lba_pkg::OP_DATA, 0, 0, 0, 0, $urandom_range(0, 255));
                        2: send_item(lba_pkg::OP_QUERY, 0, 0, $urandom_range(0, 255), 0, 0);
                        3: send_item(lba_pkg::OP_ALLOC, 0, 0, $urandom_range(0, 255), 0, 0);
                        default: begin
                            if (free_cnt < lba_pkg::CNT_MAX)
                                send_item(lba_pkg::OP_ALLOC, 0, 0, $urandom_range(0, 255),
                                          $urandom_range(free_cnt + 1, 127), 0);
                            else
                                send_item(lba_pkg::OP_QUERY, 0, 0,
                                          $urandom_range(0, 255), 0, 0);
                        end
                    endcase
                end
            end
            n = ($urandom_range(0, 7) == 0) ? 8 : $urandom_range(1, 4);
            if (n > spare.size()) n = spare.size();
            chain = {};
            chain.push_back(int'(cursor));
            repeat (n - 1) chain.push_back(take_random(spare));
            target = take_random(spare);
            if ($urandom_range(0, 1)) begin
                for (int k = 0; k < n; k++)
                    send_item(lba_pkg::OP_LINK, chain[k],
                              (k < n - 1) ? chain[k+1] : target, 0, 0, 0);
            end else begin
                for (int k = n - 1; k >= 0; k--)
                    send_item(lba_pkg::OP_LINK, chain[k],
                              (k < n - 1) ? chain[k+1] : target, 0, 0, 0);
            end
            own = ($urandom_range(0, 2) != 0) ? $urandom_range(16, 19) : $urandom_range(0, 255);
            len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, n) : n;
            send_item(lba_pkg::OP_ALLOC, 0, 0, own, len, 0);
            repeat ($urandom_range(0, len + 1))
                send_item(lba_pkg::OP_DATA, 0, 0, 0, 0, $urandom_range(0, 255));
            if ($urandom_range(0, 3) == 0) wait_drained();
            send_item(lba_pkg::OP_QUERY, 0, 0,
                      ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : own, 0, 0);
        end
    endtask

    // One chain through all blocks: free count saturates, the walk hits the
    // block limit, the owner holds every block and the cursor falls off the end.
    task automatic test_full_chain_walk();
        int rest[$];
        int path[$];
        int own;
        gather_blocks(rest, 1'b0);
        path.push_back(int'(cursor));
        while (rest.size() != 0) path.push_back(take_random(rest));
        for (int k = 0; k < lba_pkg::BLOCK_COUNT - 1; k++)
            send_item(lba_pkg::OP_LINK, path[k], path[k+1], 0, 0, 0);
        send_item(lba_pkg::OP_LINK, path[lba_pkg::BLOCK_COUNT-1], $urandom_range(64, 127),
                  0, 0, 0);
        while (free_cnt < lba_pkg::CNT_MAX)
            send_item(lba_pkg::OP_LINK, path[lba_pkg::BLOCK_COUNT-1], lba_pkg::END_MARK,
                      0, 0, 0);
        repeat (3)
            send_item(lba_pkg::OP_LINK, path[lba_pkg::BLOCK_COUNT-1],
                      $urandom_range(64, 127), 0, 0, 0);
        own = $urandom_range(0, 255);
        send_item(lba_pkg::OP_ALLOC, 0, 0, own, 127, 0);
        repeat (6) send_item(lba_pkg::OP_DATA, 0, 0, 0, 0, $urandom_range(0, 255));
        wait_drained();
        send_item(lba_pkg::OP_QUERY, 0, 0, own, 0, 0);
        send_item(lba_pkg::OP_ALLOC, 0, 0, own, 1, 0);
        send_item(lba_pkg::OP_QUERY, 0, 0, own ^ 8'h80, 0, 0);
        send_item(lba_pkg::OP_DATA, 0, 0, 0, 0, $urandom_range(0, 255));
    endtask

    initial begin
        for (int i = 0; i < lba_pkg::BLOCK_COUNT; i++) begin
            link_tab[i]  = lba_pkg::END_MARK;
            owner_tab[i] = UNOWNED;
            byte_tab[i]  = '0;
        end
        free_cnt  = '0;
        cursor    = '0;
        fill_ptr  = lba_pkg::END_MARK;
        fill_left = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_empty_tables();
        test_first_grant();
        test_takeover_and_refill();
        test_random_chains();
        test_full_chain_walk();
        wait_drained();
        repeat (2 * lba_pkg::BLOCK_COUNT + 20) @(posedge i_clk);
        if (failures == 0)
            $display("** linked_block_allocator: PASSED **");
        else
            $display("** linked_block_allocator: FAILED **");
        $finish;
    end

endmodule

[filelist.f]
+incdir+src
src/lba_pkg.sv
src/lba_datapath.sv
src/lba_ctrl.sv
src/linked_block_allocator.sv
verif/linked_block_allocator_tb.sv
